/* hdl/cmfuv_pkg.sv */
// Shared types and constants for the cube map face and UV block.
package cmfuv_pkg;

  localparam int COORD_BITS = 16;
  localparam int UV_BITS    = 16;
  localparam int RW         = COORD_BITS + 2;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    face_t               face;
    logic [UV_BITS-1:0]  tex_u;
    logic [UV_BITS-1:0]  tex_v;
    logic                zero_vector;
  } out_item_t;

  typedef struct packed {
    logic  valid;
    logic  zero;
    face_t face;
  } ctl_t;

  typedef struct packed {
    logic [RW-1:0]      ru;
    logic [RW-1:0]      rv;
    logic [RW-1:0]      den;
    logic [UV_BITS-1:0] qu;
    logic [UV_BITS-1:0] qv;
  } div_t;

endpackage

/* hdl/cmfuv_face_sel.sv */
// Face selection stage: major axis, in-face numerators and denominator.
module cmfuv_face_sel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  cmfuv_pkg::in_item_t in_item,
  output cmfuv_pkg::ctl_t    ctl_out,
  output cmfuv_pkg::div_t    div_out
);
  import cmfuv_pkg::*;

  logic signed [RW-1:0] xs, ys, zs;
  logic signed [RW-1:0] ax, ay, az;
  logic signed [RW-1:0] m, uc, vc;
  logic                 ty, tz;
  face_t                face;
  ctl_t                 ctl_r, ctl_nxt;
  div_t                 div_r, div_nxt;

  always_comb begin
    xs = RW'(in_item.dir_x);
    ys = RW'(in_item.dir_y);
    zs = RW'(in_item.dir_z);
    ax = (xs < 0) ? -xs : xs;
    ay = (ys < 0) ? -ys : ys;
    az = (zs < 0) ? -zs : zs;
    ty = (ay >= ax) && (ay >= az);
    tz = (az >= ax) && (az >= ay);
    priority if (tz) begin
      m    = az;
      vc   = ys;
      face = (zs > 0) ? FACE_PZ : FACE_NZ;
      uc   = (zs > 0) ? xs : -xs;
    end else if (ty) begin
      m    = ay;
      uc   = xs;
      face = (ys > 0) ? FACE_PY : FACE_NY;
      vc   = (ys > 0) ? -zs : zs;
    end else begin
      m    = ax;
      vc   = ys;
      face = (xs > 0) ? FACE_PX : FACE_NX;
      uc   = (xs > 0) ? -zs : zs;
    end
    ctl_nxt.valid = in_take;
    ctl_nxt.zero  = (m == '0);
    ctl_nxt.face  = face;
    div_nxt.ru    = RW'(uc + m);
    div_nxt.rv    = RW'(vc + m);
    div_nxt.den   = RW'(m <<< 1);
    div_nxt.qu    = '0;
    div_nxt.qv    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.zero <= ctl_nxt.zero;
    ctl_r.face <= ctl_nxt.face;
    div_r      <= div_nxt;
  end

  assign ctl_out = ctl_r;
  assign div_out = div_r;

endmodule

/* hdl/cmfuv_div_cell.sv */
// One divider cell: develops one quotient bit of u and of v per item.
module cmfuv_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  cmfuv_pkg::ctl_t ctl_in,
  input  cmfuv_pkg::div_t div_in,
  output cmfuv_pkg::ctl_t ctl_out,
  output cmfuv_pkg::div_t div_out
);
  import cmfuv_pkg::*;

  logic [RW-1:0] ru2, rv2;
  logic          bu, bv;
  ctl_t          ctl_r;
  div_t          div_r, div_nxt;

  always_comb begin
    ru2         = div_in.ru << 1;
    rv2         = div_in.rv << 1;
    bu          = (ru2 >= div_in.den);
    bv          = (rv2 >= div_in.den);
    div_nxt.ru  = bu ? (ru2 - div_in.den) : ru2;
    div_nxt.rv  = bv ? (rv2 - div_in.den) : rv2;
    div_nxt.den = div_in.den;
    div_nxt.qu  = {div_in.qu[UV_BITS-2:0], bu};
    div_nxt.qv  = {div_in.qv[UV_BITS-2:0], bv};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.zero <= ctl_in.zero;
    ctl_r.face <= ctl_in.face;
    div_r      <= div_nxt;
  end

  assign ctl_out = ctl_r;
  assign div_out = div_r;

endmodule

/* hdl/cube_map_face_uv.sv */
// Top level of the cube map face selection and face UV block.
//
// Input channel: an item (dir_x, dir_y, dir_z, signed Q2.14) is taken at a
// rising edge where start is high and busy is low. busy stays low, so a new
// item may be started in every cycle.
// Result channel: out_valid is high for exactly one cycle with face, tex_u,
// tex_v (unsigned Q0.16) and zero_vector on out_item. The receiver cannot
// stall; every result is taken in the cycle it appears.
// Path: an item goes from the start edge to out_valid through the face
// selection register, one divider cell per quotient bit and one output register.
// Throughput: one item per cycle, set by the chain of divider cells, each
// holding one item in flight.
// Reset: synchronous, active low; clears all valid flags so no result
// appears until an item is started.
module cube_map_face_uv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cmfuv_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output cmfuv_pkg::out_item_t out_item
);
  import cmfuv_pkg::*;

  ctl_t      ctl_chain [UV_BITS+1];
  div_t      div_chain [UV_BITS+1];
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  assign busy = 1'b0;

  cmfuv_face_sel u_face_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (start && !busy),
    .in_item (in_item),
    .ctl_out (ctl_chain[0]),
    .div_out (div_chain[0])
  );

  for (genvar i = 0; i < UV_BITS; i++) begin : g_cell
    cmfuv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_chain[i]),
      .div_in  (div_chain[i]),
      .ctl_out (ctl_chain[i+1]),
      .div_out (div_chain[i+1])
    );
  end

  always_comb begin
    out_item_nxt.face        = ctl_chain[UV_BITS].face;
    out_item_nxt.zero_vector = ctl_chain[UV_BITS].zero;
    out_item_nxt.tex_u       = ctl_chain[UV_BITS].zero ? '0 : div_chain[UV_BITS].qu;
    out_item_nxt.tex_v       = ctl_chain[UV_BITS].zero ? '0 : div_chain[UV_BITS].qv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_chain[UV_BITS].valid;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* dv/cube_map_face_uv_checker.sv */
// Checker for cube_map_face_uv: predicts each face/UV result and compares it.
`timescale 1ns / 100ps

module cube_map_face_uv_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  cmfuv_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  cmfuv_pkg::out_item_t out_item,
  output int                   pending_cnt,
  output int                   accepted_cnt,
  output int                   checked_cnt,
  output int                   zero_cnt,
  output logic [5:0]           face_seen,
  output int                   fail_cnt
);
  import cmfuv_pkg::*;

  localparam longint UV_MAX = (64'd1 << UV_BITS) - 1;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    in_item_t  dir;
    out_item_t want;
  } lookup_t;

  lookup_t    face_uv_due[$];
  int         n_accepted;
  int         n_checked;
  int         n_zero;
  int         n_fail;
  logic [5:0] faces_hit;

  initial begin
    n_accepted = 0;
    n_checked  = 0;
    n_zero     = 0;
    n_fail     = 0;
    faces_hit  = '0;
  end

  function automatic logic [UV_BITS-1:0] scale_to_unit(longint c, longint m);
    longint q;
    q = ((c + m) <<< UV_BITS) / (2 * m);
    if (q > UV_MAX) q = UV_MAX;
    return q[UV_BITS-1:0];
  endfunction

  function automatic out_item_t predict_face_uv(in_item_t it);
    longint    x, y, z, ax, ay, az, m, uc, vc;
    face_t     f;
    out_item_t r;
    x  = longint'($signed(it.dir_x));
    y  = longint'($signed(it.dir_y));
    z  = longint'($signed(it.dir_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    f  = FACE_NZ;
    m  = 0;
    uc = 0;
    vc = 0;
    if (ax >= ay && ax >= az) begin
      m  = ax;
      vc = y;
      if (x > 0) begin
        f  = FACE_PX;
        uc = -z;
      end else begin
        f  = FACE_NX;
        uc = z;
      end
    end
    if (ay >= ax && ay >= az) begin
      m  = ay;
      uc = x;
      if (y > 0) begin
        f  = FACE_PY;
        vc = -z;
      end else begin
        f  = FACE_NY;
        vc = z;
      end
    end
    if (az >= ax && az >= ay) begin
      m  = az;
      vc = y;
      if (z > 0) begin
        f  = FACE_PZ;
        uc = x;
      end else begin
        f  = FACE_NZ;
        uc = -x;
      end
    end
    if (m == 0) begin
      r.face        = FACE_NZ;
      r.tex_u       = '0;
      r.tex_v       = '0;
      r.zero_vector = 1'b1;
    end else begin
      r.face        = f;
      r.tex_u       = scale_to_unit(uc, m);
      r.tex_v       = scale_to_unit(vc, m);
      r.zero_vector = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (n_fail < MAX_PRINTED) $display("checker @%0t: %s", $realtime, what);
    n_fail++;
  endtask

  always @(posedge clk) begin
    lookup_t got_due;
    lookup_t due;
    if (rst_n) begin
      if (start && !busy) begin
        got_due.dir  = in_item;
        got_due.want = predict_face_uv(in_item);
        face_uv_due.push_back(got_due);
        n_accepted++;
      end
      if (out_valid) begin
        if (face_uv_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result face %0d u %0d v %0d zero %0b",
                                    out_item.face, out_item.tex_u, out_item.tex_v,
                                    out_item.zero_vector));
        end else begin
          due = face_uv_due.pop_front();
          n_checked++;
          if (out_item.face !== due.want.face || out_item.tex_u !== due.want.tex_u ||
              out_item.tex_v !== due.want.tex_v ||
              out_item.zero_vector !== due.want.zero_vector) begin
            report_mismatch($sformatf(
              "dir (%0d,%0d,%0d) got f%0d u%0d v%0d z%0b want f%0d u%0d v%0d z%0b",
              $signed(due.dir.dir_x), $signed(due.dir.dir_y), $signed(due.dir.dir_z),
              out_item.face, out_item.tex_u, out_item.tex_v, out_item.zero_vector,
              due.want.face, due.want.tex_u, due.want.tex_v, due.want.zero_vector));
          end
          if (due.want.zero_vector) n_zero++;
          else faces_hit[due.want.face] = 1'b1;
        end
      end
    end
    pending_cnt  <= face_uv_due.size();
    accepted_cnt <= n_accepted;
    checked_cnt  <= n_checked;
    zero_cnt     <= n_zero;
    face_seen    <= faces_hit;
    fail_cnt     <= n_fail;
  end

endmodule

/* dv/tb_cube_map_face_uv.sv */
// Testbench top for cube_map_face_uv: clock, reset, direction stimulus and verdict.
`timescale 1ns / 100ps

module tb_cube_map_face_uv;
  import cmfuv_pkg::*;

  localparam int LATENCY    = UV_BITS + 2;
  localparam int PHASE_DIRS = 475;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  int         pending_cnt;
  int         accepted_cnt;
  int         checked_cnt;
  int         zero_cnt;
  logic [5:0] face_seen;
  int         fail_cnt;

  always #6 clk = ~clk;

  cube_map_face_uv dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  cube_map_face_uv_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .pending_cnt  (pending_cnt),
    .accepted_cnt (accepted_cnt),
    .checked_cnt  (checked_cnt),
    .zero_cnt     (zero_cnt),
    .face_seen    (face_seen),
    .fail_cnt     (fail_cnt)
  );

  function automatic logic signed [COORD_BITS-1:0] coord(int v);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(5))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic in_item_t random_dir();
    in_item_t it;
    int       a[3];
    int       m;
    int       j;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        for (int k = 0; k < 3; k++) a[k] = int'($urandom_range(65535)) - 32768;
      end
      4, 5: begin
        for (int k = 0; k < 3; k++) a[k] = int'($urandom_range(16)) - 8;
      end
      6, 7, 8: begin
        // equal magnitudes on two or three axes: ties and full-scale u/v
        m = $urandom_range(32768);
        for (int k = 0; k < 3; k++) begin
          a[k] = $urandom_range(1) ? m : -m;
          if (a[k] > 32767) a[k] = 32767;
        end
        j = $urandom_range(3);
        if (j < 3) a[j] = $urandom_range(1) ? int'($urandom_range(m)) :
                                              -int'($urandom_range(m));
      end
      default: begin
        for (int k = 0; k < 3; k++) a[k] = extreme_coord();
      end
    endcase
    it.dir_x = coord(a[0]);
    it.dir_y = coord(a[1]);
    it.dir_z = coord(a[2]);
    return it;
  endfunction

  task automatic drive_dir(in_item_t it, int idle_pct);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_item <= random_dir();
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drive_xyz(int x, int y, int z);
    in_item_t it;
    it.dir_x = coord(x);
    it.dir_y = coord(y);
    it.dir_z = coord(z);
    drive_dir(it, 0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    int idle_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_xyz(0, 0, 0);
    drive_xyz(32767, 0, 0);
    drive_xyz(-32768, 0, 0);
    drive_xyz(0, 32767, 0);
    drive_xyz(0, -32768, 0);
    drive_xyz(0, 0, 32767);
    drive_xyz(0, 0, -32768);
    drive_xyz(100, 100, 0);
    drive_xyz(0, 100, -100);
    drive_xyz(-7, 7, 7);
    drive_xyz(32767, 32767, 32767);
    drive_xyz(-32768, -32768, -32768);
    drive_xyz(1000, 0, -1000);
    drive_xyz(1000, 1000, -500);
    drive_xyz(1000, -1000, 0);
    drive_xyz(300, -20, 299);
    drive_xyz(-300, 20, -299);
    drive_xyz(5, -40, 3);
    drive_xyz(1, 0, 0);
    drive_xyz(-1, 0, 0);
    drive_xyz(0, 0, 1);
    drive_xyz(-32768, 32767, -32767);
    drive_xyz(32767, -32768, 32767);
    drive_xyz(-32768, -32768, 0);
    drain_results();

    // no idling, sender idle 80%, receiver-only (no effect), sender idle 37% (receiver never stalls)
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 80;
        3: idle_pct = 37;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_DIRS; n++) drive_dir(random_dir(), idle_pct);
      drain_results();
    end

    repeat (LATENCY + 8) @(posedge clk);
    $display("tb: %0d directions sent over four idle profiles, %0d results checked",
             accepted_cnt, checked_cnt);
    $display("tb: %0d zero vectors, faces reached (bit per face) %06b, %0d mismatches",
             zero_cnt, face_seen, fail_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
